// ===== rtl/tkv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tagged key/value store package
// Shared sizes, operation codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package tkv_pkg;

   // Store geometry.
   localparam int ENTRIES        = 8;
   localparam int TAGS_PER_ENTRY = 2;

   // Derived widths.
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int CAP_W   = 4;
   localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int LIVE_W  = 4;
   localparam int WORD_W  = 32;

   // Capacity after reset.
   localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(8);

   // Request operations.
   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_GET    = 2'd1,
      OP_REMOVE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic execute;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
   } status_type;

endpackage : tkv_pkg
`default_nettype wire

// ===== rtl/tagged_key_value_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tagged key/value store
// Eight-entry key/value store with per-entry tags: add, get, remove by tag
// and clear, each request giving one result with the live entry count.
//
// Usage:
//   The request channel (req_valid / req_stall) carries an operation with key,
//   value, tags and query tag. The result channel (rsp_valid / rsp_stall)
//   returns success, the found value and the live count, one per request.
//   The capacity register is written over csr_valid / csr_ready (always
//   ready); it resets to eight. The user writes it only while the block is
//   idle; the block itself does not enforce this. A request is captured
//   while the capture/execute sequencer is idle and executed once the result
//   register can take it: all entries are compared in parallel and the
//   result register is loaded. No new request is taken until it has executed.
//   A new request is taken while an earlier result still waits in the result
//   register. If the receiver stalls, execution waits for that register to
//   free up and req_stall stays high meanwhile.
//   Synchronous reset empties the store, zeroes the count and drops any
//   pending result.
// ----------------------------------------------------------------------------
module tagged_key_value_store
   import tkv_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [1:0]               req_operation,
   input  wire logic signed [WORD_W-1:0] req_key,
   input  wire logic signed [WORD_W-1:0] req_value,
   input  wire logic [1:0]               req_tag_count,
   input  wire logic signed [WORD_W-1:0] req_first_tag,
   input  wire logic signed [WORD_W-1:0] req_second_tag,
   input  wire logic signed [WORD_W-1:0] req_query_tag,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic                          rsp_success,
   output logic signed [WORD_W-1:0]      rsp_found_value,
   output logic [LIVE_W-1:0]             rsp_live_count,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CAP_W-1:0]         csr_data
);

   cmd_type    cmd;
   status_type status;

   // The capacity register takes a write in any cycle.
   assign csr_ready = 1'b1;

   // Sequencer.
   tkv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Storage and compare logic.
   tkv_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_operation   (req_operation),
      .req_key         (req_key),
      .req_value       (req_value),
      .req_tag_count   (req_tag_count),
      .req_first_tag   (req_first_tag),
      .req_second_tag  (req_second_tag),
      .req_query_tag   (req_query_tag),
      .csr_valid       (csr_valid),
      .csr_data        (csr_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_success     (rsp_success),
      .rsp_found_value (rsp_found_value),
      .rsp_live_count  (rsp_live_count)
   );

endmodule : tagged_key_value_store
`default_nettype wire

// ===== rtl/tkv_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tagged key/value store controller
// Two-state sequencer: take a request, then execute it once the result
// register can accept the outcome.
// ----------------------------------------------------------------------------
module tkv_ctrl
   import tkv_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Requests are taken only while idle.
   assign req_stall = (state_ff != ST_IDLE);

   // Next state and commands.
   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.out_free) begin
               cmd.execute = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule : tkv_ctrl
`default_nettype wire

// ===== rtl/tkv_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tagged key/value store datapath
// Request register, entry storage with parallel key and tag compare,
// free-slot encoder, occupancy, capacity register and result register.
// ----------------------------------------------------------------------------
module tkv_datapath
   import tkv_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire cmd_type                  cmd,
   output status_type                    status,
   input  wire logic [1:0]               req_operation,
   input  wire logic signed [WORD_W-1:0] req_key,
   input  wire logic signed [WORD_W-1:0] req_value,
   input  wire logic [1:0]               req_tag_count,
   input  wire logic signed [WORD_W-1:0] req_first_tag,
   input  wire logic signed [WORD_W-1:0] req_second_tag,
   input  wire logic signed [WORD_W-1:0] req_query_tag,
   input  wire logic                     csr_valid,
   input  wire logic [CAP_W-1:0]         csr_data,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic                          rsp_success,
   output logic signed [WORD_W-1:0]      rsp_found_value,
   output logic [LIVE_W-1:0]             rsp_live_count
);

   // Captured request.
   op_type             op_ff;
   logic [WORD_W-1:0]  key_ff;
   logic [WORD_W-1:0]  value_ff;
   logic [1:0]         tag_count_ff;
   logic [WORD_W-1:0]  first_tag_ff;
   logic [WORD_W-1:0]  second_tag_ff;
   logic [WORD_W-1:0]  query_tag_ff;

   // Entry storage.
   logic [ENTRIES-1:0] live_ff;
   logic [ENTRIES-1:0] live_in;
   logic [WORD_W-1:0]  slot_key_ff   [ENTRIES];
   logic [WORD_W-1:0]  slot_value_ff [ENTRIES];
   logic [WORD_W-1:0]  slot_tag_ff   [ENTRIES][TAGS_PER_ENTRY];
   logic               tag_used_ff   [ENTRIES][TAGS_PER_ENTRY];
   logic [CNT_W-1:0]   occupancy_ff;
   logic [CNT_W-1:0]   occupancy_in;
   logic [CAP_W-1:0]   capacity_ff;

   // Result register.
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               success_ff;
   logic               success_in;
   logic [WORD_W-1:0]  found_value_ff;
   logic [WORD_W-1:0]  found_value_in;

   // Compare results.
   logic [ENTRIES-1:0] key_hit;
   logic [ENTRIES-1:0] tag_hit;
   logic               any_key;
   logic               any_free;
   logic [IDX_W-1:0]   key_idx;
   logic [IDX_W-1:0]   free_idx;
   logic [CNT_W-1:0]   removed;
   logic               add_ok;
   logic               write_slot;
   logic               new_used     [TAGS_PER_ENTRY];
   logic [WORD_W-1:0]  new_tag      [TAGS_PER_ENTRY];

   // The result register frees up when empty or when taken this cycle.
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   // Parallel key and tag compare over the live entries.
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         key_hit[i] = live_ff[i] && (slot_key_ff[i] == key_ff);
         tag_hit[i] = 1'b0;
         for (int j = 0; j < TAGS_PER_ENTRY; j++) begin
            if (tag_used_ff[i][j] && (slot_tag_ff[i][j] == query_tag_ff)) begin
               tag_hit[i] = 1'b1;
            end
         end
         tag_hit[i] = tag_hit[i] && live_ff[i];
      end
   end

   // Lowest matching key and lowest free slot, plus the removal count.
   always_comb begin
      any_key  = 1'b0;
      any_free = 1'b0;
      key_idx  = '0;
      free_idx = '0;
      removed  = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (key_hit[i]) begin
            any_key = 1'b1;
            key_idx = IDX_W'(i);
         end
         if (!live_ff[i]) begin
            any_free = 1'b1;
            free_idx = IDX_W'(i);
         end
      end
      for (int i = 0; i < ENTRIES; i++) begin
         removed = removed + CNT_W'(tag_hit[i]);
      end
   end

   // Tags of a new entry; a second tag equal to the first is dropped.
   always_comb begin
      for (int j = 0; j < TAGS_PER_ENTRY; j++) begin
         new_used[j] = 1'b0;
         new_tag[j]  = '0;
         if (j == 0) begin
            new_used[j] = (tag_count_ff != 2'd0);
            new_tag[j]  = first_tag_ff;
         end else if (j == 1) begin
            new_used[j] = tag_count_ff[1] && (second_tag_ff != first_tag_ff);
            new_tag[j]  = second_tag_ff;
         end
      end
   end

   assign add_ok = (CMP_W'(occupancy_ff) < CMP_W'(capacity_ff)) && !any_key && any_free;
   assign write_slot = cmd.execute && (op_ff == OP_ADD) && add_ok;

   // Next live bits, occupancy and result for the executed request.
   always_comb begin
      live_in        = live_ff;
      occupancy_in   = occupancy_ff;
      success_in     = 1'b1;
      found_value_in = '0;
      case (op_ff)
         OP_ADD: begin
            success_in = add_ok;
            if (add_ok) begin
               live_in[free_idx] = 1'b1;
               occupancy_in      = occupancy_ff + CNT_W'(1);
            end
         end
         OP_GET: begin
            success_in = any_key;
            if (any_key) begin
               found_value_in = slot_value_ff[key_idx];
            end
         end
         OP_REMOVE: begin
            live_in      = live_ff & ~tag_hit;
            occupancy_in = occupancy_ff - removed;
         end
         OP_CLEAR: begin
            live_in      = '0;
            occupancy_in = '0;
         end
         default: begin
            live_in = live_ff;
         end
      endcase
   end

   // Result valid holds until the receiver takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.execute) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state: live bits, occupancy, capacity, result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff      <= '0;
         occupancy_ff <= '0;
         capacity_ff  <= CAPACITY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.execute) begin
            live_ff      <= live_in;
            occupancy_ff <= occupancy_in;
         end
         if (csr_valid) begin
            capacity_ff <= csr_data;
         end
      end
   end

   // Payload registers: request, entries and result.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff         <= op_type'(req_operation);
         key_ff        <= req_key;
         value_ff      <= req_value;
         tag_count_ff  <= req_tag_count;
         first_tag_ff  <= req_first_tag;
         second_tag_ff <= req_second_tag;
         query_tag_ff  <= req_query_tag;
      end
      if (write_slot) begin
         slot_key_ff[free_idx]   <= key_ff;
         slot_value_ff[free_idx] <= value_ff;
         for (int j = 0; j < TAGS_PER_ENTRY; j++) begin
            slot_tag_ff[free_idx][j] <= new_tag[j];
            tag_used_ff[free_idx][j] <= new_used[j];
         end
      end
      if (cmd.execute) begin
         success_ff     <= success_in;
         found_value_ff <= found_value_in;
      end
   end

   // Result outputs.
   logic [LIVE_W-1:0] live_count_ff;

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         live_count_ff <= LIVE_W'(occupancy_in);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_success     = success_ff;
   assign rsp_found_value = found_value_ff;
   assign rsp_live_count  = live_count_ff;

endmodule : tkv_datapath
`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tagged key/value store testbench
// Runs a directed list of requests, then random phases under several capacity
// settings and idle patterns. A shadow copy of the store predicts every
// result, and each result is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb;
   import tkv_pkg::*;

   localparam int CYCLE_LIMIT = 100000;
   localparam int TAIL_CYCLES = 8;
   localparam int TAG_SLOTS   = ENTRIES * TAGS_PER_ENTRY;
   localparam logic [31:0] WORD_MAX  = 32'h7fff_ffff;
   localparam logic [31:0] WORD_MIN  = 32'h8000_0000;
   localparam logic [31:0] WORD_ONES = 32'hffff_ffff;

   // Random phases: capacity, request count and idle percentages.
   localparam int PHASES = 6;
   localparam int PHASE_CAPACITY [PHASES]  = '{8, 2, 15, 1, 0, 5};
   localparam int PHASE_REQUESTS [PHASES]  = '{150, 60, 150, 50, 30, 210};
   localparam int PHASE_SEND_IDLE [PHASES] = '{35, 35, 65, 65, 0, 0};
   localparam int PHASE_RECV_IDLE [PHASES] = '{65, 65, 35, 35, 0, 0};

   typedef struct packed {
      op_type      operation;
      logic [31:0] key;
      logic [31:0] value;
      logic [1:0]  tag_count;
      logic [31:0] first_tag;
      logic [31:0] second_tag;
      logic [31:0] query_tag;
   } store_request_type;

   typedef struct packed {
      logic              success;
      logic [31:0]       found_value;
      logic [LIVE_W-1:0] live_count;
   } store_result_type;

   typedef enum bit {ROW_REQ, ROW_CAP} row_kind_type;

   // One directed row. A capacity row carries the new capacity in value.
   typedef struct packed {
      row_kind_type      kind;
      op_type            operation;
      logic [31:0]       key;
      logic [31:0]       value;
      logic [1:0]        tag_count;
      logic [31:0]       first_tag;
      logic [31:0]       second_tag;
      logic [31:0]       query_tag;
      bit                typed;
      logic              success;
      logic [31:0]       found_value;
      logic [LIVE_W-1:0] live_count;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 29;

   // Rows with typed set carry their expected result; the rest use the shadow store.
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      // Empty store: get misses, remove matches nothing.
      '{ROW_REQ, OP_GET,    0,        0,         0, 0,         0,        0,        1, 0, 0,        0},
      '{ROW_REQ, OP_REMOVE, 0,        0,         0, 0,         0,        0,        1, 1, 0,        0},
      // Extreme keys and values; equal tags attach once, a count of 3 acts as 2.
      '{ROW_REQ, OP_ADD,    WORD_MAX, WORD_MIN,  2, 5,         5,        0,        1, 1, 0,        1},
      '{ROW_REQ, OP_ADD,    WORD_MIN, WORD_MAX,  3, WORD_ONES, WORD_MIN, 0,        1, 1, 0,        2},
      // Duplicate key is refused.
      '{ROW_REQ, OP_ADD,    WORD_MAX, 1,         0, 0,         0,        0,        1, 0, 0,        2},
      '{ROW_REQ, OP_GET,    WORD_MAX, 0,         0, 0,         0,        0,        1, 1, WORD_MIN, 2},
      // An entry with no tags is never hit by remove, even for tag zero.
      '{ROW_REQ, OP_ADD,    0,        WORD_ONES, 0, 0,         0,        0,        1, 1, 0,        3},
      '{ROW_REQ, OP_REMOVE, 0,        0,         0, 0,         0,        0,        1, 1, 0,        3},
      '{ROW_REQ, OP_REMOVE, 0,        0,         0, 0,         0,        5,        1, 1, 0,        2},
      // A count of 1 drops the second tag.
      '{ROW_REQ, OP_ADD,    1,        2,         1, WORD_MIN,  7,        0,        1, 1, 0,        3},
      '{ROW_REQ, OP_REMOVE, 0,        0,         0, 0,         0,        7,        1, 1, 0,        3},
      '{ROW_REQ, OP_REMOVE, 0,        0,         0, 0,         0,        WORD_MIN, 1, 1, 0,        1},
      // Fill every slot.
      '{ROW_REQ, OP_ADD,    2,        202,       2, 2,         100,      0,        0, 0, 0,        0},
      '{ROW_REQ, OP_ADD,    3,        203,       2, 3,         100,      0,        0, 0, 0,        0},
      '{ROW_REQ, OP_ADD,    4,        204,       2, 4,         100,      0,        0, 0, 0,        0},
      '{ROW_REQ, OP_ADD,    5,        205,       2, 5,         100,      0,        0, 0, 0,        0},
      '{ROW_REQ, OP_ADD,    6,        206,       2, 6,         100,      0,        0, 0, 0,        0},
      '{ROW_REQ, OP_ADD,    7,        207,       2, 7,         100,      0,        0, 0, 0,        0},
      '{ROW_REQ, OP_ADD,    8,        208,       2, 8,         100,      0,        0, 0, 0,        0},
      '{ROW_REQ, OP_ADD,    9,        209,       2, 9,         100,      0,        1, 0, 0,        8},
      // Capacity below the live count.
      '{ROW_CAP, OP_GET,    0,        3,         0, 0,         0,        0,        0, 0, 0,        0},
      '{ROW_REQ, OP_ADD,    10,       210,       0, 0,         0,        0,        1, 0, 0,        8},
      // Capacity above the slot count, with no slot free.
      '{ROW_CAP, OP_GET,    0,        15,        0, 0,         0,        0,        0, 0, 0,        0},
      '{ROW_REQ, OP_ADD,    11,       211,       0, 0,         0,        0,        1, 0, 0,        8},
      '{ROW_REQ, OP_GET,    4,        0,         0, 0,         0,        0,        0, 0, 0,        0},
      '{ROW_REQ, OP_REMOVE, 0,        0,         0, 0,         0,        100,      1, 1, 0,        1},
      // Zero capacity refuses every add.
      '{ROW_CAP, OP_GET,    0,        0,         0, 0,         0,        0,        0, 0, 0,        0},
      '{ROW_REQ, OP_ADD,    12,       212,       1, 12,        0,        0,        1, 0, 0,        1},
      // Clear ignores every other field.
      '{ROW_REQ, OP_CLEAR,  WORD_ONES, WORD_MIN, 3, WORD_ONES, WORD_MAX, WORD_ONES, 1, 1, 0,       0}
   };

   // Clock and reset.
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Block ports.
   logic              req_valid       = 1'b0;
   logic              req_stall;
   logic [1:0]        req_operation   = '0;
   logic [31:0]       req_key         = '0;
   logic [31:0]       req_value       = '0;
   logic [1:0]        req_tag_count   = '0;
   logic [31:0]       req_first_tag   = '0;
   logic [31:0]       req_second_tag  = '0;
   logic [31:0]       req_query_tag   = '0;
   logic              rsp_valid;
   logic              rsp_stall       = 1'b0;
   logic              rsp_success;
   logic [31:0]       rsp_found_value;
   logic [LIVE_W-1:0] rsp_live_count;
   logic              csr_valid       = 1'b0;
   logic              csr_ready;
   logic [CAP_W-1:0]  csr_data        = '0;

   tagged_key_value_store uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_key         (req_key),
      .req_value       (req_value),
      .req_tag_count   (req_tag_count),
      .req_first_tag   (req_first_tag),
      .req_second_tag  (req_second_tag),
      .req_query_tag   (req_query_tag),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_success     (rsp_success),
      .rsp_found_value (rsp_found_value),
      .rsp_live_count  (rsp_live_count),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data)
   );

   // Shadow copy of the store and its capacity register.
   logic [CAP_W-1:0] shadow_capacity = CAPACITY_RESET;
   bit               shadow_live     [ENTRIES];
   bit [31:0]        shadow_key      [ENTRIES];
   bit [31:0]        shadow_value    [ENTRIES];
   bit [31:0]        shadow_tag      [TAG_SLOTS];
   bit               shadow_tag_used [TAG_SLOTS];
   int               shadow_occupancy = 0;

   store_result_type pending_results [$];

   int send_idle_pct   = 0;
   int recv_idle_pct   = 0;
   int error_count     = 0;
   int results_checked = 0;
   int cycle_count     = 0;
   int capacity_writes = 0;
   int op_requests [4] = '{0, 0, 0, 0};
   int adds_stored     = 0;
   int gets_found      = 0;

   // Applies one request to the shadow store and returns its result.
   function automatic store_result_type apply_to_store(input store_request_type r);
      store_result_type res;
      int hit;
      int free_slot;
      int base;
      int used;
      int i;
      int j;
      res = '{success: 1'b1, found_value: '0, live_count: '0};
      hit = -1;
      free_slot = -1;
      // Lowest live slot holding the key and lowest free slot.
      for (i = ENTRIES - 1; i >= 0; i--) begin
         if (shadow_live[i] && shadow_key[i] == r.key) hit = i;
         if (!shadow_live[i]) free_slot = i;
      end
      case (r.operation)
         OP_ADD: begin
            if (shadow_occupancy >= int'(shadow_capacity) || hit >= 0 || free_slot < 0) begin
               res.success = 1'b0;
            end else begin
               shadow_live[free_slot]  = 1'b1;
               shadow_key[free_slot]   = r.key;
               shadow_value[free_slot] = r.value;
               base = free_slot * TAGS_PER_ENTRY;
               for (j = 0; j < TAGS_PER_ENTRY; j++) begin
                  shadow_tag_used[base + j] = 1'b0;
                  shadow_tag[base + j]      = '0;
               end
               // A count of 3 behaves as 2; a repeated tag is kept once.
               used = 0;
               if (r.tag_count >= 1) begin
                  shadow_tag[base]      = r.first_tag;
                  shadow_tag_used[base] = 1'b1;
                  used = 1;
               end
               if (r.tag_count >= 2 && r.second_tag != r.first_tag && used < TAGS_PER_ENTRY) begin
                  shadow_tag[base + used]      = r.second_tag;
                  shadow_tag_used[base + used] = 1'b1;
               end
               shadow_occupancy++;
            end
         end
         OP_GET: begin
            if (hit >= 0) res.found_value = shadow_value[hit];
            else res.success = 1'b0;
         end
         OP_REMOVE: begin
            for (i = 0; i < ENTRIES; i++) begin
               for (j = 0; j < TAGS_PER_ENTRY; j++) begin
                  if (shadow_live[i] && shadow_tag_used[i * TAGS_PER_ENTRY + j] &&
                      shadow_tag[i * TAGS_PER_ENTRY + j] == r.query_tag) begin
                     shadow_live[i] = 1'b0;
                     shadow_occupancy--;
                  end
               end
            end
         end
         default: begin
            for (i = 0; i < ENTRIES; i++) shadow_live[i] = 1'b0;
            shadow_occupancy = 0;
         end
      endcase
      res.live_count = LIVE_W'(shadow_occupancy);
      return res;
   endfunction

   // Mostly small values so keys and tags collide, with extremes and full words mixed in.
   function automatic logic [31:0] pool_word(input int span);
      int pick;
      pick = $urandom_range(span + 4);
      case (pick)
         0:       return $urandom;
         1:       return WORD_MIN;
         2:       return WORD_MAX;
         3:       return WORD_ONES;
         default: return 32'(pick - 4);
      endcase
   endfunction

   function automatic store_request_type random_request();
      store_request_type r;
      int pick;
      pick = $urandom_range(99);
      if (pick < 40) r.operation = OP_ADD;
      else if (pick < 72) r.operation = OP_GET;
      else if (pick < 92) r.operation = OP_REMOVE;
      else r.operation = OP_CLEAR;
      r.key        = pool_word(9);
      r.value      = $urandom;
      r.tag_count  = 2'($urandom_range(3));
      r.first_tag  = pool_word(5);
      r.second_tag = ($urandom_range(3) == 0) ? r.first_tag : pool_word(5);
      r.query_tag  = pool_word(5);
      return r;
   endfunction

   // Drives one request after a random gap and records its expected result.
   task automatic send_request(input store_request_type r, input bit typed,
                               input store_result_type typed_result);
      store_result_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_operation  <= r.operation;
      req_key        <= r.key;
      req_value      <= r.value;
      req_tag_count  <= r.tag_count;
      req_first_tag  <= r.first_tag;
      req_second_tag <= r.second_tag;
      req_query_tag  <= r.query_tag;
      req_valid      <= 1'b1;
      do @(posedge clock); while (req_stall);
      predicted = apply_to_store(r);
      pending_results.push_back(typed ? typed_result : predicted);
      op_requests[r.operation]++;
      if (r.operation == OP_ADD && predicted.success) adds_stored++;
      if (r.operation == OP_GET && predicted.success) gets_found++;
   endtask

   // Holds off new requests until every outstanding result is back.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] capacity);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= capacity;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      shadow_capacity = capacity;
      capacity_writes++;
   endtask

   // Result checking and random stall of the result channel.
   always @(posedge clock) begin
      store_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("Result arrived with no request outstanding");
               error_count++;
            end else begin
               want = pending_results.pop_front();
               results_checked++;
               if (rsp_success !== want.success) begin
                  $error("success: expected %0b, got %0b", want.success, rsp_success);
                  error_count++;
               end
               if (rsp_found_value !== want.found_value) begin
                  $error("found_value: expected %h, got %h", want.found_value, rsp_found_value);
                  error_count++;
               end
               if (rsp_live_count !== want.live_count) begin
                  $error("live_count: expected %0d, got %0d", want.live_count, rsp_live_count);
                  error_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Directed rows, then random phases, then the final report.
   initial begin
      directed_row_type row;
      store_request_type r;
      store_result_type typed_result;
      int p;
      int n;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = PHASE_SEND_IDLE[0];
      recv_idle_pct = PHASE_RECV_IDLE[0];
      for (n = 0; n < DIRECTED_ROWS; n++) begin
         row = directed_rows[n];
         if (row.kind == ROW_CAP) begin
            write_capacity(row.value[CAP_W-1:0]);
         end else begin
            r = '{row.operation, row.key, row.value, row.tag_count,
                  row.first_tag, row.second_tag, row.query_tag};
            typed_result = '{row.success, row.found_value, row.live_count};
            send_request(r, row.typed, typed_result);
         end
      end

      for (p = 0; p < PHASES; p++) begin
         write_capacity(CAP_W'(PHASE_CAPACITY[p]));
         send_idle_pct = PHASE_SEND_IDLE[p];
         recv_idle_pct = PHASE_RECV_IDLE[p];
         for (n = 0; n < PHASE_REQUESTS[p]; n++) begin
            send_request(random_request(), 1'b0, '0);
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Checked %0d results over %0d capacity writes: %0d adds (%0d stored), %0d gets",
               results_checked, capacity_writes, op_requests[OP_ADD], adds_stored,
               op_requests[OP_GET]);
      $display("(%0d found), %0d removals by tag and %0d clears.",
               gets_found, op_requests[OP_REMOVE], op_requests[OP_CLEAR]);
      if (error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/tkv_pkg.sv
rtl/tkv_ctrl.sv
rtl/tkv_datapath.sv
rtl/tagged_key_value_store.sv
sim/tb.sv
